>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the vertex transform.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, muted while reset is high.
`define VMT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define VMT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/vmt_pkg.sv
// Shared types and constants of the fixed-point vertex matrix transform.
package vmt_pkg;

   // Fixed-point word and default fraction width
   localparam int COORD_W           = 32;
   localparam int FRAC_BITS_DEFAULT = 16;

   // Matrix geometry
   localparam int NUM_ROWS  = 4;
   localparam int NUM_TERMS = 3;

   // Register file
   localparam int NUM_CSR   = 8;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_W     = 64;

   // Stream payloads
   localparam int REQ_W = NUM_TERMS * COORD_W;
   localparam int RSP_W = NUM_ROWS * COORD_W;

   typedef logic signed [COORD_W-1:0]   fix_type;
   typedef logic signed [2*COORD_W-1:0] prod_type;
   typedef logic [CSR_W-1:0]            csr_word_type;
   typedef logic [CSR_IDX_W-1:0]        csr_index_type;

   // Register indexes
   localparam csr_index_type CSR_ROW0_COLS01 = 4'd0;
   localparam csr_index_type CSR_ROW0_COLS23 = 4'd1;
   localparam csr_index_type CSR_ROW1_COLS01 = 4'd2;
   localparam csr_index_type CSR_ROW1_COLS23 = 4'd3;
   localparam csr_index_type CSR_ROW2_COLS01 = 4'd4;
   localparam csr_index_type CSR_ROW2_COLS23 = 4'd5;
   localparam csr_index_type CSR_ROW3_COLS01 = 4'd6;
   localparam csr_index_type CSR_ROW3_COLS23 = 4'd7;

   // Reset contents: identity at 16 fraction bits
   localparam csr_word_type CSR_RESET [NUM_CSR] = '{
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000
   };

endpackage

>>> rtl/vertex_matrix_transform_unit.sv
// Top level of the pipelined fixed-point 4x4 affine vertex transform.
//
//  Channel | Direction | Handshake           | Payload
//  req     | in        | req_tvalid/tready   | x, y, z (3 x 32 bit signed)
//  rsp     | out       | rsp_tvalid/tready   | x, y, z, w (4 x 32 bit signed)
//  csr     | in        | csr_valid/ready     | 4 bit register index, 64 bit data
//
// One vertex per clock unless the result stream stalls; from accepted beat to result beat the stages are:
// operand register, twelve parallel 32x32 multipliers, pair adds, final add.
// Each stage holds its own valid bit and advances whenever the next stage frees,
// so bubbles close up and a stalled result stalls only the stages behind it.
// Reset is synchronous: valid bits clear and the matrix returns to its reset value.
// The configuration port is always ready; indexes beyond the list are dropped.
module vertex_matrix_transform_unit #(
   parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // req stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [vmt_pkg::REQ_W-1:0]        req_tdata,   // x_in, y_in, z_in
   // rsp stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [vmt_pkg::RSP_W-1:0]        rsp_tdata,   // x_out, y_out, z_out, w_out
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  vmt_pkg::csr_index_type           csr_index,
   input  vmt_pkg::csr_word_type            csr_data
);

   localparam int CW = vmt_pkg::COORD_W;

   // Matrix registers
   vmt_pkg::csr_word_type cfg_ff [vmt_pkg::NUM_CSR];

   // Matrix entries by row and column
   vmt_pkg::fix_type mat [vmt_pkg::NUM_ROWS][vmt_pkg::NUM_ROWS];

   // Stage valid bits and advance strobes
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;

   // Stage 1: operands
   vmt_pkg::fix_type coord_ff [vmt_pkg::NUM_TERMS];
   vmt_pkg::fix_type coord_in [vmt_pkg::NUM_TERMS];

   // Stage 2: products
   vmt_pkg::prod_type prod_ff [vmt_pkg::NUM_ROWS][vmt_pkg::NUM_TERMS];
   vmt_pkg::prod_type prod_in [vmt_pkg::NUM_ROWS][vmt_pkg::NUM_TERMS];

   // Stage 3: partial sums
   logic [CW-1:0] sum_a_ff [vmt_pkg::NUM_ROWS];
   logic [CW-1:0] sum_b_ff [vmt_pkg::NUM_ROWS];
   logic [CW-1:0] sum_a_in [vmt_pkg::NUM_ROWS];
   logic [CW-1:0] sum_b_in [vmt_pkg::NUM_ROWS];

   // Stage 4: result beat
   logic [vmt_pkg::RSP_W-1:0] rsp_data_ff;
   logic [vmt_pkg::RSP_W-1:0] rsp_data_in;

   // Accept every configuration beat
   assign csr_ready = 1'b1;

   // Write a matrix register, drop indexes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vmt_pkg::NUM_CSR; i++) begin
            cfg_ff[i] <= vmt_pkg::CSR_RESET[i];
         end
      end else if (csr_valid && csr_ready &&
                   (csr_index <= vmt_pkg::CSR_ROW3_COLS23)) begin
         cfg_ff[csr_index[2:0]] <= csr_data;
      end
   end

   // Unpack two entries per register, even column in the low half
   always_comb begin
      for (int r = 0; r < vmt_pkg::NUM_ROWS; r++) begin
         mat[r][0] = cfg_ff[2*r][CW-1:0];
         mat[r][1] = cfg_ff[2*r][2*CW-1:CW];
         mat[r][2] = cfg_ff[2*r+1][CW-1:0];
         mat[r][3] = cfg_ff[2*r+1][2*CW-1:CW];
      end
   end

   // Advance a stage when it is empty or the next one moves
   assign adv4       = !v4_ff || rsp_tready;
   assign adv3       = !v3_ff || adv4;
   assign adv2       = !v2_ff || adv3;
   assign adv1       = !v1_ff || adv2;
   assign req_tready = adv1;

   // Carry valid bits down the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= req_tvalid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
         if (adv4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // Split the request beat into coordinates
   always_comb begin
      for (int t = 0; t < vmt_pkg::NUM_TERMS; t++) begin
         coord_in[t] = req_tdata[t*CW +: CW];
      end
   end

   // Multiply each coordinate by its matrix entry
   always_comb begin
      for (int r = 0; r < vmt_pkg::NUM_ROWS; r++) begin
         for (int t = 0; t < vmt_pkg::NUM_TERMS; t++) begin
            prod_in[r][t] = mat[r][t] * coord_ff[t];
         end
      end
   end

   // Scale products back to 32 bits and add in pairs, translation with the last term
   always_comb begin
      for (int r = 0; r < vmt_pkg::NUM_ROWS; r++) begin
         sum_a_in[r] = prod_ff[r][0][FRAC_BITS +: CW] + prod_ff[r][1][FRAC_BITS +: CW];
         sum_b_in[r] = prod_ff[r][2][FRAC_BITS +: CW] + mat[r][3];
      end
   end

   // Close each row sum into the result beat
   always_comb begin
      for (int r = 0; r < vmt_pkg::NUM_ROWS; r++) begin
         rsp_data_in[r*CW +: CW] = sum_a_ff[r] + sum_b_ff[r];
      end
   end

   // Payload registers, held while their stage stalls
   always_ff @(posedge clock) begin
      if (adv1) begin
         coord_ff <= coord_in;
      end
      if (adv2) begin
         prod_ff <= prod_in;
      end
      if (adv3) begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
      if (adv4) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/vmt_checker.sv
// Port-level checks of the vertex transform, bound to its top level.
`include "assert_macros.svh"

module vmt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [vmt_pkg::RSP_W-1:0]        rsp_tdata,
   input logic                             csr_ready
);

   // A result beat waiting on the consumer holds its data
   `VMT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp beat changed while stalled")

   // The pipe only pushes back when the result beat itself is stalled
   `VMT_ASSERT(a_backpressure, clock, reset, !req_tready |-> rsp_tvalid && !rsp_tready, "req stalled without a stalled rsp beat")

   // Reset empties the pipe
   `VMT_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_tvalid, "rsp beat right after reset")

   // Configuration port never pushes back
   `VMT_ASSERT(a_csr_ready, clock, reset, csr_ready, "csr port not ready")

endmodule

bind vertex_matrix_transform_unit vmt_checker u_vmt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the fixed-point 4x4 affine vertex transform unit.
module testbench;

   localparam int CLK_PERIOD     = 12;
   localparam int FRAC           = vmt_pkg::FRAC_BITS_DEFAULT;
   localparam int CW             = vmt_pkg::COORD_W;
   localparam int NROWS          = vmt_pkg::NUM_ROWS;
   localparam int PIPE_LATENCY   = 4;
   localparam int HOLD_CYCLES    = 400;
   localparam int TIMEOUT_CYCLES = 800_000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_BEATS    = 190;
   localparam int MAX_REPORTS    = 10;

   typedef logic [vmt_pkg::RSP_W-1:0] rsp_word_type;

   // Value spread used for random matrix entries and coordinates
   typedef enum int {
      SPREAD_FULL,
      SPREAD_UNIT,
      SPREAD_EDGE
   } spread_type;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [vmt_pkg::REQ_W-1:0]    req_tdata  = '0;    // x_in, y_in, z_in
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [vmt_pkg::RSP_W-1:0]    rsp_tdata;          // x_out, y_out, z_out, w_out
   logic                         csr_valid  = 1'b0;
   logic                         csr_ready;
   vmt_pkg::csr_index_type       csr_index  = '0;
   vmt_pkg::csr_word_type        csr_data   = '0;

   // Shadow matrix and outstanding transformed vertices
   vmt_pkg::fix_type matrix [NROWS][NROWS];
   rsp_word_type     transformed_q [$];
   string            field_names [NROWS] = '{"x_out", "y_out", "z_out", "w_out"};

   bit req_gaps_on   = 1'b0;
   bit rsp_stalls_on = 1'b0;
   bit hold_rsp      = 1'b0;
   int mismatches         = 0;
   int beats_sent         = 0;
   int beats_checked      = 0;
   int csr_writes         = 0;
   int input_stall_cycles = 0;

   vertex_matrix_transform_unit #(
      .FRAC_BITS (FRAC)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Signed product, arithmetic shift by the fraction bits, keep low word
   function automatic vmt_pkg::fix_type scaled_product(vmt_pkg::fix_type a,
                                                       vmt_pkg::fix_type b);
      vmt_pkg::prod_type p;
      p = vmt_pkg::prod_type'(a) * vmt_pkg::prod_type'(b);
      p = p >>> FRAC;
      return p[CW-1:0];
   endfunction

   // Row-major matrix times (x, y, z, 1), each row sum wrapping at 32 bits
   function automatic rsp_word_type transform_vertex(vmt_pkg::fix_type x,
                                                     vmt_pkg::fix_type y,
                                                     vmt_pkg::fix_type z);
      rsp_word_type     res;
      vmt_pkg::fix_type acc;
      for (int r = 0; r < NROWS; r++) begin
         acc = scaled_product(matrix[r][0], x) + scaled_product(matrix[r][1], y)
             + scaled_product(matrix[r][2], z) + matrix[r][3];
         res[r*CW +: CW] = acc;
      end
      return res;
   endfunction

   // Mirror a register write into the shadow matrix; drop unused indexes
   function automatic void store_csr(vmt_pkg::csr_index_type idx,
                                     vmt_pkg::csr_word_type data);
      int row;
      int col;
      if (idx < vmt_pkg::NUM_CSR) begin
         row = int'(idx) / 2;
         col = (int'(idx) % 2) * 2;
         matrix[row][col]     = data[CW-1:0];
         matrix[row][col + 1] = data[vmt_pkg::CSR_W-1:CW];
      end
   endfunction

   function automatic vmt_pkg::fix_type rand_fix(spread_type spread);
      case (spread)
         SPREAD_FULL: return $urandom();
         SPREAD_UNIT: return int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         default: begin
            case ($urandom_range(0, 5))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0000;
               3:       return 32'h0000_0001;
               4:       return 32'hFFFF_FFFF;
               default: return 32'h0001_0000;
            endcase
         end
      endcase
   endfunction

   // Mostly short idle stretches, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one vertex beat and hold it until accepted
   task automatic send_vertex(vmt_pkg::fix_type x, vmt_pkg::fix_type y,
                              vmt_pkg::fix_type z);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      transformed_q.push_back(transform_vertex(x, y, z));
      beats_sent++;
   endtask

   // Write one register; csr_valid stays high for a following write
   task automatic write_csr(vmt_pkg::csr_index_type idx, vmt_pkg::csr_word_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      store_csr(idx, data);
      csr_writes++;
   endtask

   task automatic load_matrix(spread_type spread);
      for (int i = 0; i < vmt_pkg::NUM_CSR; i++)
         write_csr(vmt_pkg::csr_index_type'(i), {rand_fix(spread), rand_fix(spread)});
      csr_valid <= 1'b0;
   endtask

   // Stop offering, wait for every result, then let the pipeline settle
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (transformed_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // Reset matrix is the identity: coordinates pass through, w is one
   task automatic test_reset_identity();
      send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
      send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000);
      send_vertex(32'h1234_5678, 32'hEDCB_A987, 32'h5A5A_5A5A);
      quiesce();
   endtask

   // Extreme entries: product overflow, sum wrap, floor of negative products
   task automatic test_directed_matrix();
      write_csr(vmt_pkg::CSR_ROW0_COLS01, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
      write_csr(vmt_pkg::CSR_ROW0_COLS23, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
      write_csr(vmt_pkg::CSR_ROW1_COLS01, {32'h8000_0000, 32'h8000_0000});
      write_csr(vmt_pkg::CSR_ROW1_COLS23, {32'h8000_0000, 32'h8000_0000});
      // half and minus half: odd coordinates land between two codes
      write_csr(vmt_pkg::CSR_ROW2_COLS01, {32'h0000_8000, 32'hFFFF_8000});
      write_csr(vmt_pkg::CSR_ROW2_COLS23, {32'h0000_0001, 32'h0000_0001});
      write_csr(vmt_pkg::CSR_ROW3_COLS01, {32'hFFFF_FFFF, 32'h0000_0000});
      write_csr(vmt_pkg::CSR_ROW3_COLS23, {32'h8000_0000, 32'h7FFF_FFFF});
      csr_valid <= 1'b0;
      send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_vertex(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
      send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vertex(32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0005);
      send_vertex(32'hFFFF_FFFD, 32'h0000_0003, 32'hFFFF_FFFB);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0001_8000);
      quiesce();
   endtask

   // Writes beyond the register list must leave the matrix alone
   task automatic test_ignored_index();
      for (int i = vmt_pkg::NUM_CSR; i < 2 ** vmt_pkg::CSR_IDX_W; i++)
         write_csr(vmt_pkg::csr_index_type'(i), {$urandom(), $urandom()});
      csr_valid <= 1'b0;
      repeat (4) send_vertex($urandom(), $urandom(), $urandom());
      quiesce();
   endtask

   // New random matrix per phase, idling on neither, one or both sides
   task automatic test_random_phases();
      spread_type spread;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_matrix(spread_type'(phase % 3));
         req_gaps_on   = phase[0];
         rsp_stalls_on = phase[1];
         for (int n = 0; n < PHASE_BEATS; n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: spread = SPREAD_FULL;
               6, 7, 8:          spread = SPREAD_UNIT;
               default:          spread = SPREAD_EDGE;
            endcase
            send_vertex(rand_fix(spread), rand_fix(spread), rand_fix(spread));
         end
         quiesce();
      end
   endtask

   // Hold off results for a long stretch while vertices keep coming
   task automatic test_backpressure();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      hold_rsp      = 1'b1;
      repeat (40) send_vertex(rand_fix(SPREAD_FULL), rand_fix(SPREAD_UNIT),
                              rand_fix(SPREAD_FULL));
      quiesce();
   endtask

   // Result-side pacing: random stalls, or a long hold when asked
   initial begin : rsp_pacer
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_stalls_on && $urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   // Compare each accepted result beat with the oldest outstanding vertex
   always @(posedge clock) begin : rsp_checker
      rsp_word_type want;
      if (!reset) begin
         if (req_tvalid && !req_tready) input_stall_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            if (transformed_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result beat with nothing outstanding, data %h",
                           $time, rsp_tdata);
            end else begin
               want = transformed_q.pop_front();
               beats_checked++;
               for (int f = 0; f < NROWS; f++) begin
                  if (rsp_tdata[f*CW +: CW] !== want[f*CW +: CW]) begin
                     mismatches++;
                     if (mismatches <= MAX_REPORTS)
                        $display("%0t: beat %0d %s expected %h got %h", $time,
                                 beats_checked, field_names[f],
                                 want[f*CW +: CW],
                                 rsp_tdata[f*CW +: CW]);
                  end
               end
            end
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : sequencer
      for (int i = 0; i < vmt_pkg::NUM_CSR; i++)
         store_csr(vmt_pkg::csr_index_type'(i), vmt_pkg::CSR_RESET[i]);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_identity();
      test_directed_matrix();
      test_ignored_index();
      test_random_phases();
      test_backpressure();
      $display("Transformed %0d vertices (%0d checked) across %0d register writes,",
               beats_sent, beats_checked, csr_writes);
      $display("including unused indexes; input held off %0d cycles, %0d mismatches",
               input_stall_cycles, mismatches);
      if (mismatches == 0 && transformed_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> vertex_matrix_transform_unit.f
+incdir+rtl
rtl/vmt_pkg.sv
rtl/vertex_matrix_transform_unit.sv
rtl/vmt_checker.sv
tb/sv/testbench.sv
